[hw/rtl/pidt_pkg.sv]
// Shared types and constants for the positional insert/delete table.
package pidt_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int TYPE_W   = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // request beat handed from the port to the sequencer
   typedef struct packed {
      logic                valid;
      req_kind_type        kind;
      logic [POS_W-1:0]    position;
      logic [DATA_W-1:0]   value;
   } req_beat_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic                done;
      status_type          status;
      logic [DATA_W-1:0]   data;
      logic [COUNT_W-1:0]  count;
   } rsp_beat_type;

endpackage

[hw/rtl/positional_insert_delete_table_core.sv]
// Top level of the positional insert/delete table: ports, output register, RAM.
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  request | req_valid/ready, req_type, req_position,      | in
//          | req_value                                     |
//  result  | rsp_valid/ready, rsp_status, rsp_data_out,    | out
//          | rsp_count_out                                 |
//
// One beat in gives one beat out; req_ready is high only while the sequencer is idle
// and reset is low. A clear or failed request goes straight to the handoff; a read
// fetches the entry at p; an insert at p shifts each entry from p up by one and then
// writes the value; a delete fetches entry p, then shifts each entry above it down.
// A result waiting in the output register does not block the next request. Reset
// clears the count and handshake state; the entry RAM is not cleared.
module positional_insert_delete_table_core #(
   parameter int CAPACITY = pidt_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pidt_pkg::TYPE_W-1:0]         req_type,
   input  logic [pidt_pkg::POS_W-1:0]          req_position,
   input  logic signed [pidt_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pidt_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [pidt_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [pidt_pkg::COUNT_W-1:0]        rsp_count_out
);

   localparam int AW = $clog2(CAPACITY);

   pidt_pkg::req_beat_type req_beat;
   pidt_pkg::rsp_beat_type rsp_beat;
   logic                   seq_idle;
   logic                   rsp_free;

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [pidt_pkg::DATA_W-1:0]   ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [pidt_pkg::DATA_W-1:0]   ram_rd_data;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pidt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [pidt_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [pidt_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // accept a request beat only while the sequencer is idle and out of reset
   assign req_ready      = seq_idle & ~reset;
   assign req_beat.valid = req_valid & req_ready;
   assign req_beat.kind  = pidt_pkg::req_kind_type'(req_type);
   assign req_beat.position = req_position;
   assign req_beat.value    = req_value;

   // the output register is free when empty or being drained this cycle
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   pidt_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_beat),
      .idle        (seq_idle),
      .rsp_free    (rsp_free),
      .rsp_beat    (rsp_beat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   pidt_ram #(
      .WIDTH (pidt_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   // load a finished result, drop it once the consumer takes the beat
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_beat.done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rsp_beat.status;
         rsp_data_in   = rsp_beat.data;
         rsp_count_in  = rsp_beat.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_count_out = rsp_count_ff;

endmodule

[hw/rtl/pidt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pidt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[hw/rtl/pidt_seq.sv]
// Sequencer: checks a request and moves entries one at a time through the RAM.
module pidt_seq #(
   parameter int CAPACITY = pidt_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pidt_pkg::req_beat_type   req_beat,
   output logic                     idle,
   input  logic                     rsp_free,
   output pidt_pkg::rsp_beat_type   rsp_beat,
   output logic                     ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
   output logic [pidt_pkg::DATA_W-1:0] ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
   input  logic [pidt_pkg::DATA_W-1:0] ram_rd_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > pidt_pkg::POS_W) ? CW : pidt_pkg::POS_W;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECIDE   = 8'b0000_0010,
      S_MV_RD    = 8'b0000_0100,
      S_MV_WR    = 8'b0000_1000,
      S_PUT      = 8'b0001_0000,
      S_RD_ISSUE = 8'b0010_0000,
      S_RD_CAP   = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               k_ff, k_in;
   pidt_pkg::req_kind_type      kind_ff, kind_in;
   logic [pidt_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [pidt_pkg::DATA_W-1:0] value_ff, value_in;
   pidt_pkg::status_type        status_ff, status_in;
   logic [pidt_pkg::DATA_W-1:0] data_ff, data_in;

   logic [PW-1:0] pos_w;
   logic [PW-1:0] cnt_w;
   logic [CW-1:0] k_dec;
   logic [CW-1:0] k_inc;
   logic          is_ins;

   assign pos_w  = PW'(pos_ff);
   assign cnt_w  = PW'(count_ff);
   assign k_dec  = k_ff - CW'(1);
   assign k_inc  = k_ff + CW'(1);
   assign is_ins = (kind_ff == pidt_pkg::REQ_INSERT);

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      data_in     = data_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = k_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = k_ff[AW-1:0];
      rsp_beat.done   = 1'b0;
      rsp_beat.status = status_ff;
      rsp_beat.data   = data_ff;
      rsp_beat.count  = pidt_pkg::COUNT_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat.valid) begin
               kind_in   = req_beat.kind;
               pos_in    = req_beat.position;
               value_in  = req_beat.value;
               status_in = pidt_pkg::ST_OK;
               data_in   = '0;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (kind_ff) inside
               pidt_pkg::REQ_CLEAR: begin
                  count_in = '0;
                  state_in = S_DONE;
               end
               pidt_pkg::REQ_INSERT: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = pidt_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else if (pos_w > cnt_w) begin
                     status_in = pidt_pkg::ST_BADPOS;
                     state_in  = S_DONE;
                  end else begin
                     k_in     = count_ff;
                     state_in = (pos_w == cnt_w) ? S_PUT : S_MV_RD;
                  end
               end
               pidt_pkg::REQ_DELETE, pidt_pkg::REQ_READ: begin
                  if (count_ff == '0) begin
                     status_in = pidt_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else if (pos_w >= cnt_w) begin
                     status_in = pidt_pkg::ST_BADPOS;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_RD_ISSUE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_MV_RD: begin
            // insert pulls from below, delete pulls from above
            ram_rd_en   = 1'b1;
            ram_rd_addr = is_ins ? k_dec[AW-1:0] : k_ff[AW-1:0];
            state_in    = S_MV_WR;
         end
         S_MV_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = is_ins ? k_ff[AW-1:0] : k_dec[AW-1:0];
            if (is_ins) begin
               k_in     = k_dec;
               state_in = (PW'(k_dec) > pos_w) ? S_MV_RD : S_PUT;
            end else begin
               k_in = k_inc;
               if (k_inc < count_ff) begin
                  state_in = S_MV_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_w[AW-1:0];
            ram_wr_data = value_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_RD_ISSUE: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_w[AW-1:0];
            state_in    = S_RD_CAP;
         end
         S_RD_CAP: begin
            data_in = ram_rd_data;
            if (kind_ff == pidt_pkg::REQ_DELETE) begin
               k_in = CW'(pos_w + PW'(1));
               if (CW'(pos_w + PW'(1)) < count_ff) begin
                  state_in = S_MV_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (rsp_free) begin
               rsp_beat.done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      k_ff      <= k_in;
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      data_ff   <= data_in;
   end

endmodule

[verif/positional_insert_delete_table_core_test.sv]
// Self-checking testbench for the positional insert/delete table core.
module positional_insert_delete_table_core_test;

   localparam int LIST_CAP     = pidt_pkg::CAPACITY_DEF;
   localparam int SAW          = $clog2(LIST_CAP);
   localparam int RANDOM_ITEMS = 1900;
   // leave headroom for the longest shift after the drain
   localparam int TAIL_CYCLES  = 4 * LIST_CAP + 20;

   typedef struct {
      pidt_pkg::status_type                status;
      logic [pidt_pkg::DATA_W-1:0]         data;
      logic [pidt_pkg::COUNT_W-1:0]        count;
   } list_result_type;

   // one directed request; fixed == 1 means the expectation is typed in below
   typedef struct {
      pidt_pkg::req_kind_type              kind;
      logic [pidt_pkg::POS_W-1:0]          pos;
      logic [pidt_pkg::DATA_W-1:0]         val;
      bit                                  fixed;
      list_result_type                     res;
   } op_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [pidt_pkg::TYPE_W-1:0]         req_type;
   logic [pidt_pkg::POS_W-1:0]          req_position;
   logic signed [pidt_pkg::DATA_W-1:0]  req_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [pidt_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [pidt_pkg::DATA_W-1:0]  rsp_data_out;
   logic [pidt_pkg::COUNT_W-1:0]        rsp_count_out;

   positional_insert_delete_table_core #(
      .CAPACITY(LIST_CAP)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_count_out(rsp_count_out)
   );

   // Shadow copy of the list, advanced once per accepted request beat.
   logic [pidt_pkg::DATA_W-1:0]  shadow_entries [LIST_CAP];
   int unsigned                  shadow_count;

   list_result_type    pending_results [$];
   op_row_type         directed_rows [$];
   int unsigned        mismatches;
   bit                 no_idle;        // set during stretches with no idling on either side
   int unsigned        rsp_hold;
   int unsigned        rsp_gap_draw;
   list_result_type    oldest;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 800000);
      $display("tb: failure");
      $finish;
   end

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // Apply one request to the shadow list and return the result it yields.
   function automatic list_result_type apply_list_op(pidt_pkg::req_kind_type kind,
                                                     logic [pidt_pkg::POS_W-1:0] pos,
                                                     logic [pidt_pkg::DATA_W-1:0] val);
      list_result_type r;
      int unsigned     p;
      int              k;
      p        = 32'(pos);
      r.status = pidt_pkg::ST_OK;
      r.data   = '0;
      case (kind)
         pidt_pkg::REQ_CLEAR: begin
            shadow_count = 0;
         end
         pidt_pkg::REQ_INSERT: begin
            // full wins over a bad position
            if (shadow_count >= LIST_CAP) begin
               r.status = pidt_pkg::ST_FULL;
            end else if (p > shadow_count) begin
               r.status = pidt_pkg::ST_BADPOS;
            end else begin
               for (k = shadow_count; k > p; k--)
                  shadow_entries[SAW'(k)] = shadow_entries[SAW'(k - 1)];
               shadow_entries[SAW'(p)] = val;
               shadow_count++;
            end
         end
         default: begin
            // empty wins over a bad position, for delete and read alike
            if (shadow_count == 0) begin
               r.status = pidt_pkg::ST_EMPTY;
            end else if (p >= shadow_count) begin
               r.status = pidt_pkg::ST_BADPOS;
            end else begin
               r.data = shadow_entries[SAW'(p)];
               if (kind == pidt_pkg::REQ_DELETE) begin
                  // move everything above down by one, the last entry included
                  for (k = p + 1; k < shadow_count; k++)
                     shadow_entries[SAW'(k - 1)] = shadow_entries[SAW'(k)];
                  shadow_count--;
               end
            end
         end
      endcase
      r.count = shadow_count[pidt_pkg::COUNT_W-1:0];
      return r;
   endfunction

   // Present one request beat after a random gap and hold it until accepted.
   // Keep valid high across back-to-back beats: only one assignment per edge.
   task automatic send_beat(pidt_pkg::req_kind_type kind, logic [pidt_pkg::POS_W-1:0] pos,
                            logic [pidt_pkg::DATA_W-1:0] val, bit fixed,
                            list_result_type fixed_res);
      int unsigned     gap;
      list_result_type predicted;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge: record what it must produce
      predicted = apply_list_op(kind, pos, val);
      pending_results.push_back(fixed ? fixed_res : predicted);
   endtask

   // Drop valid and hold off until every outstanding result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Result side: stall a random number of cycles before each beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= draw_gap();
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            rsp_gap_draw = draw_gap();
            if (rsp_gap_draw != 0) begin
               rsp_ready <= 1'b0;
               rsp_hold  <= rsp_gap_draw;
            end
         end
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: status %0d data %h count %0d",
                        rsp_status, rsp_data_out, rsp_count_out);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status || rsp_data_out !== oldest.data ||
                rsp_count_out !== oldest.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: status exp %0d got %0d, data exp %h got %h,",
                            " count exp %0d got %0d"},
                           oldest.status, rsp_status, oldest.data, rsp_data_out,
                           oldest.count, rsp_count_out);
            end
         end
      end
   end

   initial begin : stimulus
      int                     i;
      int                     k;
      int unsigned            r;
      int unsigned            p;
      bit                     growing;
      pidt_pkg::req_kind_type kind;
      op_row_type             row;
      list_result_type        none;

      none         = '{pidt_pkg::ST_OK, '0, '0};
      mismatches   = 0;
      shadow_count = 0;
      no_idle      = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_type     <= pidt_pkg::REQ_CLEAR;
      req_position <= '0;
      req_value    <= '0;

      // Directed rows: empty list, extremes of value, precedence of the checks.
      directed_rows.push_back('{pidt_pkg::REQ_READ,   5'd0,  32'h0,        1,
                                '{pidt_pkg::ST_EMPTY,  32'h0, 5'd0}});
      directed_rows.push_back('{pidt_pkg::REQ_DELETE, 5'd5,  32'h0,        1,
                                '{pidt_pkg::ST_EMPTY,  32'h0, 5'd0}});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd1,  32'h1234,     1,
                                '{pidt_pkg::ST_BADPOS, 32'h0, 5'd0}});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd0,  32'h7FFFFFFF, 1,
                                '{pidt_pkg::ST_OK,     32'h0, 5'd1}});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd0,  32'h80000000, 1,
                                '{pidt_pkg::ST_OK,     32'h0, 5'd2}});
      directed_rows.push_back('{pidt_pkg::REQ_READ,   5'd1,  32'h0,        1,
                                '{pidt_pkg::ST_OK, 32'h7FFFFFFF, 5'd2}});
      directed_rows.push_back('{pidt_pkg::REQ_READ,   5'd16, 32'h0,        1,
                                '{pidt_pkg::ST_BADPOS, 32'h0, 5'd2}});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd2,  32'hFFFFFFFF, 1,
                                '{pidt_pkg::ST_OK,     32'h0, 5'd3}});
      directed_rows.push_back('{pidt_pkg::REQ_DELETE, 5'd0,  32'h0,        1,
                                '{pidt_pkg::ST_OK, 32'h80000000, 5'd2}});
      directed_rows.push_back('{pidt_pkg::REQ_CLEAR,  5'd9,  32'h5A5A5A5A, 1,
                                '{pidt_pkg::ST_OK,     32'h0, 5'd0}});
      // fill to capacity, appending each time
      for (k = 0; k < LIST_CAP; k++)
         directed_rows.push_back('{pidt_pkg::REQ_INSERT, k[pidt_pkg::POS_W-1:0],
                                   32'h01010101 * k, 1,
                                   '{pidt_pkg::ST_OK, 32'h0, pidt_pkg::COUNT_W'(k + 1)}});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd16, 32'h1,        1,
                                '{pidt_pkg::ST_FULL,   32'h0, 5'd16}});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd0,  32'h2,        1,
                                '{pidt_pkg::ST_FULL,   32'h0, 5'd16}});
      directed_rows.push_back('{pidt_pkg::REQ_DELETE, 5'd16, 32'h0,        1,
                                '{pidt_pkg::ST_BADPOS, 32'h0, 5'd16}});
      directed_rows.push_back('{pidt_pkg::REQ_DELETE, 5'd15, 32'h0,        0, none});
      directed_rows.push_back('{pidt_pkg::REQ_DELETE, 5'd0,  32'h0,        0, none});
      directed_rows.push_back('{pidt_pkg::REQ_INSERT, 5'd15, 32'h3,        1,
                                '{pidt_pkg::ST_BADPOS, 32'h0, 5'd14}});
      directed_rows.push_back('{pidt_pkg::REQ_READ,   5'd13, 32'h0,        0, none});
      directed_rows.push_back('{pidt_pkg::REQ_CLEAR,  5'd0,  32'h0,        1,
                                '{pidt_pkg::ST_OK,     32'h0, 5'd0}});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.kind, row.pos, row.val, row.fixed, row.res);
      end

      // Random part: alternate growing and shrinking stretches so the list
      // reaches both full and empty; most positions are legal for the count.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         growing = ((i / 120) % 2) == 0;
         no_idle = ((i / 200) % 5) == 4;
         if (i == RANDOM_ITEMS / 2) drain_results();
         r = $urandom_range(0, 99);
         if (r < 3)
            kind = pidt_pkg::REQ_CLEAR;
         else if (r < (growing ? 58 : 28))
            kind = pidt_pkg::REQ_INSERT;
         else if (r < (growing ? 75 : 70))
            kind = pidt_pkg::REQ_DELETE;
         else
            kind = pidt_pkg::REQ_READ;
         if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, 16);
         else if (kind == pidt_pkg::REQ_INSERT)
            p = $urandom_range(0, shadow_count);
         else
            p = (shadow_count == 0) ? $urandom_range(0, 16)
                                    : $urandom_range(0, shadow_count - 1);
         send_beat(kind, p[pidt_pkg::POS_W-1:0], $urandom(), 0, none);
      end

      no_idle = 1'b0;
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
